// File: rtl/tlb_lru_pkg.sv
package tlb_lru_pkg;

  // fixed width of the virtual and physical address words
  localparam int unsigned VaWidth = 16;

  // default geometry
  localparam int unsigned TlbEntriesDef = 16;
  localparam int unsigned PageCountDef  = 256;
  localparam int unsigned FrameCountDef = 256;
  localparam int unsigned OffsetBitsDef = 8;

  // commands from the sequencer to the associative tag store
  typedef struct packed {
    logic touch;  // make the matching entry the most recent
    logic fill;   // write page/frame into the victim slot
  } cam_cmd_t;

endpackage

// File: rtl/tlb_lru_cam.sv
module tlb_lru_cam
  import tlb_lru_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = TlbEntriesDef,
  parameter int unsigned PAGE_W      = 8,
  parameter int unsigned FRAME_W     = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cam_cmd_t           cmd_i,
  input  logic [PAGE_W-1:0]  page_i,
  input  logic [FRAME_W-1:0] fill_frame_i,
  output logic               hit_o,
  output logic [FRAME_W-1:0] hit_frame_o
);

  localparam int unsigned IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned RANK_W = IDX_W;

  logic [TLB_ENTRIES-1:0] valid_q, valid_d;
  logic [PAGE_W-1:0]      page_q  [TLB_ENTRIES];
  logic [FRAME_W-1:0]     frame_q [TLB_ENTRIES];
  logic [RANK_W-1:0]      rank_q  [TLB_ENTRIES];
  logic [RANK_W-1:0]      rank_d  [TLB_ENTRIES];

  logic [TLB_ENTRIES-1:0] match;
  logic [TLB_ENTRIES-1:0] empty;
  logic [TLB_ENTRIES-1:0] low_empty;
  logic [IDX_W-1:0]       empty_idx;
  logic [IDX_W-1:0]       oldest_idx;
  logic [IDX_W-1:0]       victim;
  logic [RANK_W-1:0]      hit_rank;
  logic [FRAME_W-1:0]     hit_frame;

  // parallel compare; at most one entry matches so results are or-reduced
  assign empty     = ~valid_q;
  assign low_empty = empty & (~empty + TLB_ENTRIES'(1));

  always_comb begin
    hit_rank   = '0;
    hit_frame  = '0;
    empty_idx  = '0;
    oldest_idx = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = valid_q[i] && (page_q[i] == page_i);
      if (match[i]) begin
        hit_rank  = hit_rank | rank_q[i];
        hit_frame = hit_frame | frame_q[i];
      end
      if (low_empty[i]) begin
        empty_idx = empty_idx | IDX_W'(i);
      end
      if (rank_q[i] == RANK_W'(TLB_ENTRIES - 1)) begin
        oldest_idx = oldest_idx | IDX_W'(i);
      end
    end
  end

  assign hit_o       = |match;
  assign hit_frame_o = hit_frame;

  // lowest empty slot, else the entry holding the oldest rank
  assign victim = (&valid_q) ? oldest_idx : empty_idx;

  // recency ranks: touched or filled entry goes to zero, younger ones age
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (cmd_i.touch) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (match[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = RANK_W'(rank_q[i] + 1'b1);
        end
      end
    end else if (cmd_i.fill) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (IDX_W'(i) == victim) begin
          valid_d[i] = 1'b1;
          rank_d[i]  = '0;
        end else if (valid_q[i]) begin
          rank_d[i] = RANK_W'(rank_q[i] + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  // tag and frame payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      page_q[victim]  <= page_i;
      frame_q[victim] <= fill_frame_i;
    end
  end

`ifndef SYNTHESIS
  a_match_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("more than one tlb entry matches the page");

  a_touch_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.touch |-> hit_o)
    else $error("touch issued without a matching entry");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fill && !(&valid_q)) |=>
      ($countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("fill into an empty slot did not add a valid entry");
`endif

endmodule

// File: rtl/tlb_lru_page_translation.sv
// Address translation with a fully associative TLB (LRU replacement) backed by
// a page table memory with demand frame assignment. After reset the block runs
// a clearing pass over every page table entry with busy high. A word is taken
// when start is high and busy is low. A TLB hit passes ST_MOD and ST_CMP and
// then shows its result with done_o; a miss also passes ST_FILL, which uses
// the registered page table read before the write-back. The next word can be
// taken at the edge that ends the result cycle, so no new word is taken while
// one is still being translated. Results are shown on
// done_o for one cycle only and must be captured then.
module tlb_lru_page_translation
  import tlb_lru_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = TlbEntriesDef,
  parameter int unsigned PAGE_COUNT  = PageCountDef,
  parameter int unsigned FRAME_COUNT = FrameCountDef,
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [VaWidth-1:0] virtual_address_i,
  output logic               done_o,
  output logic [VaWidth-1:0] phys_addr_o,
  output logic               tlb_hit_o,
  output logic               page_fault_o
);

  localparam int unsigned PAGE_W  = $clog2(PAGE_COUNT);
  localparam int unsigned FRAME_W = $clog2(FRAME_COUNT);
  localparam int unsigned RAW_W   = (OFFSET_BITS >= VaWidth) ? 1 : VaWidth - OFFSET_BITS;
  // page = raw mod PAGE_COUNT through a reciprocal and one correction step
  localparam int unsigned SHIFT   = RAW_W + PAGE_W;
  localparam int unsigned RECIP_W = RAW_W + 2;
  localparam longint unsigned RECIP = (64'd1 << SHIFT) / PAGE_COUNT;
  localparam int unsigned PROD_W  = RAW_W + RECIP_W;
  localparam int unsigned MOD_W   = RAW_W + PAGE_W + 1;
  localparam logic [VaWidth:0]   OFF_LIMIT = (VaWidth + 1)'(1) << OFFSET_BITS;
  localparam logic [VaWidth-1:0] OFF_MASK  = VaWidth'(OFF_LIMIT - 1'b1);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [PAGE_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic [FRAME_W-1:0] next_frame_q, next_frame_d;
  logic [VaWidth-1:0] va_q;
  logic [RAW_W-1:0]   quo_q;
  logic [PAGE_W-1:0]  page_q;
  logic               done_q, done_d;
  logic [VaWidth-1:0] pa_q, pa_d;
  logic               hit_q, hit_d;
  logic               fault_q, fault_d;

  logic               accept;
  logic [RAW_W-1:0]   raw_in;
  logic [PROD_W-1:0]  prod;
  logic [RAW_W-1:0]   quo;
  logic [RAW_W-1:0]   raw_q;
  logic [MOD_W-1:0]   qp;
  logic [MOD_W-1:0]   diff;
  logic [PAGE_W-1:0]  page_d;

  // page table memory: {mapped, frame}
  logic [FRAME_W:0]   map_mem [PAGE_COUNT];
  logic [FRAME_W:0]   map_rd_q;
  logic               mem_we;
  logic [PAGE_W-1:0]  mem_waddr;
  logic [FRAME_W:0]   mem_wdata;

  cam_cmd_t           cam_cmd;
  logic               cam_hit;
  logic [FRAME_W-1:0] cam_frame;
  logic [FRAME_W-1:0] fill_frame;
  logic               map_valid;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // quotient estimate from the incoming word
  assign raw_in = RAW_W'(virtual_address_i >> OFFSET_BITS);
  assign prod   = PROD_W'(raw_in) * PROD_W'(RECIP);
  assign quo    = RAW_W'(prod >> SHIFT);

  // remainder with one correction
  assign raw_q  = RAW_W'(va_q >> OFFSET_BITS);
  assign qp     = MOD_W'(quo_q) * MOD_W'(PAGE_COUNT);
  assign diff   = MOD_W'(raw_q) - qp;
  assign page_d = (diff >= MOD_W'(PAGE_COUNT)) ? PAGE_W'(diff - MOD_W'(PAGE_COUNT))
                                                : PAGE_W'(diff);

  assign map_valid  = map_rd_q[FRAME_W];
  assign fill_frame = map_valid ? map_rd_q[FRAME_W-1:0] : next_frame_q;

  tlb_lru_cam #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_W      (PAGE_W),
    .FRAME_W     (FRAME_W)
  ) u_cam (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cam_cmd),
    .page_i       (page_q),
    .fill_frame_i (fill_frame),
    .hit_o        (cam_hit),
    .hit_frame_o  (cam_frame)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    next_frame_d = next_frame_q;
    done_d       = 1'b0;
    pa_d         = pa_q;
    hit_d        = hit_q;
    fault_d      = fault_q;
    cam_cmd      = '0;
    mem_we       = 1'b0;
    mem_waddr    = page_q;
    mem_wdata    = {1'b1, next_frame_q};
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        if (clr_cnt_q == PAGE_W'(PAGE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = PAGE_W'(clr_cnt_q + 1'b1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (cam_hit) begin
          cam_cmd.touch = 1'b1;
          pa_d    = VaWidth'(32'(cam_frame) << OFFSET_BITS) | (va_q & OFF_MASK);
          hit_d   = 1'b1;
          fault_d = 1'b0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        cam_cmd.fill = 1'b1;
        if (!map_valid) begin
          mem_we = 1'b1;
          if (next_frame_q == FRAME_W'(FRAME_COUNT - 1)) begin
            next_frame_d = '0;
          end else begin
            next_frame_d = FRAME_W'(next_frame_q + 1'b1);
          end
        end
        pa_d    = VaWidth'(32'(fill_frame) << OFFSET_BITS) | (va_q & OFF_MASK);
        hit_d   = 1'b0;
        fault_d = !map_valid;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      next_frame_q <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      next_frame_q <= next_frame_d;
      done_q       <= done_d;
    end
  end

  // word and datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      va_q  <= virtual_address_i;
      quo_q <= quo;
    end
    if (state_q == ST_MOD) begin
      page_q <= page_d;
    end
    pa_q    <= pa_d;
    hit_q   <= hit_d;
    fault_q <= fault_d;
  end

  // page table port: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    map_rd_q <= map_mem[page_q];
  end

  assign done_o       = done_q;
  assign phys_addr_o  = pa_q;
  assign tlb_hit_o    = hit_q;
  assign page_fault_o = fault_q;

`ifndef SYNTHESIS
  a_hit_fault_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(tlb_hit_o && page_fault_o))
    else $error("hit and fault reported together");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_CMP || $past(state_q) == ST_FILL))
    else $error("result strobe without a finished lookup");

  a_accept_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_MOD))
    else $error("accepted word did not enter the page stage");

  a_fill_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> !cam_hit)
    else $error("tlb fill while the page is present");
`endif

endmodule

// File: bench/tlb_lru_page_translation_tb.sv
`timescale 1ns / 100ps

module tlb_lru_page_translation_tb;
  import tlb_lru_pkg::*;

  localparam int unsigned Entries     = TlbEntriesDef;
  localparam int unsigned Pages       = PageCountDef;
  localparam int unsigned Frames      = FrameCountDef;
  localparam int unsigned OffBits     = OffsetBitsDef;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 8;

  typedef struct {
    logic [VaWidth-1:0] phys_addr;
    logic               tlb_hit;
    logic               page_fault;
  } xlat_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [VaWidth-1:0] virtual_address_i;
  logic               done_o;
  logic [VaWidth-1:0] phys_addr_o;
  logic               tlb_hit_o;
  logic               page_fault_o;

  tlb_lru_page_translation DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .virtual_address_i (virtual_address_i),
    .done_o            (done_o),
    .phys_addr_o       (phys_addr_o),
    .tlb_hit_o         (tlb_hit_o),
    .page_fault_o      (page_fault_o)
  );

  // translation state mirrored in the bench
  bit          tlb_valid_m [Entries];
  logic [7:0]  tlb_page_m  [Entries];
  logic [7:0]  tlb_frame_m [Entries];
  int unsigned tlb_rank_m  [Entries];
  bit          map_valid_m [Pages];
  logic [7:0]  map_frame_m [Pages];
  logic [7:0]  next_frame_m;

  xlat_t       expected_xlat_q[$];
  int unsigned error_count;
  int unsigned quiet_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // make slot idx the most recent; valid entries younger than limit age by one
  function automatic void promote_slot(int unsigned idx, int unsigned limit);
    for (int unsigned i = 0; i < Entries; i++) begin
      if (i != idx && tlb_valid_m[i] && tlb_rank_m[i] < limit) begin
        tlb_rank_m[i]++;
      end
    end
    tlb_rank_m[idx] = 0;
  endfunction

  // predict one translation and advance the mirrored state
  function automatic xlat_t translate_address(logic [VaWidth-1:0] va);
    xlat_t       res;
    logic [7:0]  page;
    logic [7:0]  frame;
    int unsigned slot;
    int unsigned oldest;
    bit          hit;
    bit          found_empty;
    page        = 8'((va >> OffBits) % Pages);
    hit         = 1'b0;
    found_empty = 1'b0;
    slot        = 0;
    res.page_fault = 1'b0;
    for (int unsigned i = 0; i < Entries; i++) begin
      if (!hit && tlb_valid_m[i] && tlb_page_m[i] == page) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    if (hit) begin
      frame = tlb_frame_m[slot];
      promote_slot(slot, tlb_rank_m[slot]);
    end else begin
      if (map_valid_m[page]) begin
        frame = map_frame_m[page];
      end else begin
        // demand assignment from the wrapping frame counter
        res.page_fault    = 1'b1;
        frame             = next_frame_m;
        map_frame_m[page] = frame;
        map_valid_m[page] = 1'b1;
        next_frame_m      = 8'((next_frame_m + 1) % Frames);
      end
      for (int unsigned i = 0; i < Entries; i++) begin
        if (!found_empty && !tlb_valid_m[i]) begin
          slot        = i;
          found_empty = 1'b1;
        end
      end
      // full: replace the oldest entry
      if (!found_empty) begin
        oldest = 0;
        for (int unsigned i = 0; i < Entries; i++) begin
          if (tlb_rank_m[i] > oldest) begin
            oldest = tlb_rank_m[i];
            slot   = i;
          end
        end
      end
      tlb_valid_m[slot] = 1'b1;
      tlb_page_m[slot]  = page;
      tlb_frame_m[slot] = frame;
      promote_slot(slot, 32'hFF);
    end
    res.phys_addr = VaWidth'((32'(frame) << OffBits) | (va & ((1 << OffBits) - 1)));
    res.tlb_hit   = hit;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [VaWidth-1:0] got,
                                 input logic [VaWidth-1:0] want);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // drive one word and hold it until it is taken
  task automatic send_word(input logic [VaWidth-1:0] va);
    @(negedge clk_i);
    start             <= 1'b1;
    virtual_address_i <= va;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_xlat_q.push_back(translate_address(va));
  endtask

  // random idle burst, with noise on the address lines
  task automatic maybe_idle();
    int unsigned gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk_i);
        start             <= 1'b0;
        virtual_address_i <= VaWidth'($urandom);
      end
    end
  endtask

  // random word, mostly drawn from a drifting working set of about 20 pages
  function automatic logic [VaWidth-1:0] pick_address(logic [7:0] ws_base);
    logic [7:0] page;
    if ($urandom_range(0, 9) < 7) begin
      page = ws_base + 8'($urandom_range(0, 19));
      return {page, 8'($urandom)};
    end
    return VaWidth'($urandom);
  endfunction

  // extremes, hits, faults, refills from the page table and LRU eviction
  task automatic test_directed();
    send_word(16'h0000);
    send_word(16'h00FF);
    send_word(16'hFFFF);
    send_word(16'hFF00);
    maybe_idle();
    for (int unsigned p = 1; p <= 14; p++) begin
      send_word({8'(p), 8'($urandom)});
      maybe_idle();
    end
    // tlb now full: touch page 0, evict the oldest, then refill it without a fault
    send_word(16'h00A5);
    send_word(16'h805A);
    send_word(16'hFF3C);
    send_word(16'h0C77);
  endtask

  // random words with working-set locality and idle bursts
  task automatic test_working_set(input int unsigned count);
    logic [7:0] ws_base;
    ws_base = 8'($urandom);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 50 == 0) ws_base = 8'($urandom);
      send_word(pick_address(ws_base));
      maybe_idle();
    end
  endtask

  // touch every page so that every mapping is made and the frame counter wraps
  task automatic test_page_sweep();
    for (int unsigned p = 0; p < Pages; p++) begin
      send_word({8'(p), 8'($urandom)});
      maybe_idle();
    end
  endtask

  // back-to-back words with no idling
  task automatic test_back_to_back(input int unsigned count);
    logic [7:0] ws_base;
    ws_base = 8'($urandom);
    for (int unsigned n = 0; n < count; n++) begin
      send_word(pick_address(ws_base));
    end
  endtask

  // check each result word against the oldest prediction
  always @(posedge clk_i) begin
    xlat_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_xlat_q.size() == 0) begin
        report_mismatch("unexpected word, phys_addr", phys_addr_o, '0);
      end else begin
        want = expected_xlat_q.pop_front();
        if (phys_addr_o !== want.phys_addr)
          report_mismatch("phys_addr", phys_addr_o, want.phys_addr);
        if (tlb_hit_o !== want.tlb_hit)
          report_mismatch("tlb_hit", VaWidth'(tlb_hit_o), VaWidth'(want.tlb_hit));
        if (page_fault_o !== want.page_fault)
          report_mismatch("page_fault", VaWidth'(page_fault_o), VaWidth'(want.page_fault));
      end
    end
  end

  // watchdog on cycles where nothing is taken or returned
  always @(posedge clk_i) begin
    if ((rst_ni && start && busy === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("ERROR %0t: watchdog timeout", $realtime);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    start             = 1'b0;
    virtual_address_i = '0;
    rst_ni            = 1'b0;
    error_count       = 0;
    quiet_cycles      = 0;
    next_frame_m      = '0;
    for (int unsigned i = 0; i < Entries; i++) begin
      tlb_valid_m[i] = 1'b0;
      tlb_rank_m[i]  = 0;
    end
    for (int unsigned i = 0; i < Pages; i++) map_valid_m[i] = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_working_set(200);
    test_page_sweep();
    test_working_set(150);
    test_back_to_back(80);

    @(negedge clk_i);
    start <= 1'b0;
    while (expected_xlat_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: tlb_lru_page_translation.f
rtl/tlb_lru_pkg.sv
rtl/tlb_lru_cam.sv
rtl/tlb_lru_page_translation.sv
bench/tlb_lru_page_translation_tb.sv
